// ===== sv/isi_pkg.sv =====
// shared constants and types for the image sample interpolator
`default_nettype none
package isi_pkg;

  localparam int FRAC_BITS = 8;
  localparam int PIX_W     = 8;
  localparam int ADDR_W    = 16;
  localparam int COORD_W   = 8;
  localparam int DIM_W     = 9;
  localparam int POS_W     = 16;
  localparam int CFG_W     = 9;
  localparam int IDX_W     = 2;
  localparam int MAX_DIM   = 256;
  localparam int STORE_DEPTH = 65536;

  // cubic weights are scaled by 6 * 2^(3*FRAC_BITS)
  localparam int WGT_W   = 30;
  localparam int ROW_W   = 41;
  localparam int SPLIT   = 20;
  localparam int PART_W  = ROW_W - SPLIT;
  localparam int ACC_W   = 66;
  localparam int ACC_SH  = 6 * FRAC_BITS;
  localparam int V_W     = ACC_W - ACC_SH;

  // divide by 36 through a scaled reciprocal, exact for values below 36*256
  localparam int SAT_LIMIT   = 36 * 256;
  localparam int RECIP_SHIFT = 20;
  localparam int RECIP_36    = (1 << RECIP_SHIFT) / 36 + 1;
  localparam int QV_W        = 14;
  localparam int Q_W         = 29;

  localparam logic [1:0] MTH_NEAREST  = 2'd0;
  localparam logic [1:0] MTH_BILINEAR = 2'd1;
  localparam logic [1:0] MTH_BICUBIC  = 2'd2;

  localparam logic [IDX_W-1:0] CFG_IMG_WIDTH  = 2'd0;
  localparam logic [IDX_W-1:0] CFG_IMG_HEIGHT = 2'd1;
  localparam logic [IDX_W-1:0] CFG_METHOD     = 2'd2;

  localparam logic CMD_WRITE  = 1'b0;
  localparam logic CMD_SAMPLE = 1'b1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SETUP1,
    ST_SETUP2,
    ST_READ,
    ST_LAST,
    ST_MUL_LO,
    ST_MUL_HI,
    ST_FINISH
  } isi_state_t;

endpackage : isi_pkg
`default_nettype wire

// ===== sv/image_sample_interpolator.sv =====
// top level of the image sample interpolator: frame store and sampling sequencer
//
// usage:
//   input channel (in_valid / in_stall) carries one transaction per item; in_cmd
//   selects a pixel write (in_pixel_addr, in_pixel_value) or a sample at the
//   fixed-point position in_pos_x / in_pos_y (8 fraction bits)
//   result channel (out_valid / out_stall) carries one out_intensity per sample;
//   writes give no result
//   config port (cfg_wr_en, cfg_index, cfg_data) sets width, height and method;
//   the user writes it only while the block is idle; the block does not enforce this
// sample sequence:
//   a write is taken without stalling the input; a sample stalls it through setup1,
//   setup2, the reads of each row (one pixel read a cycle from the single port
//   frame store) and a last-read step, for bicubic then a low and a high multiply
//   step per row, and finish, which registers the result; no new item is taken meanwhile
// reset:
//   clears the sequencer and the output valid flag and loads width 256, height 256,
//   nearest mode; the frame store is not cleared and must be written before use
// stall:
//   a finished result waits in the output register; the block keeps taking
//   writes and starts the next sample, which waits at its end if still stalled
`default_nettype none
module image_sample_interpolator
  import isi_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  output logic                   in_stall,
  input  wire logic              in_cmd,
  input  wire logic [ADDR_W-1:0] in_pixel_addr,
  input  wire logic [PIX_W-1:0]  in_pixel_value,
  input  wire logic [POS_W-1:0]  in_pos_x,
  input  wire logic [POS_W-1:0]  in_pos_y,
  output logic                   out_valid,
  input  wire logic              out_stall,
  output logic [PIX_W-1:0]       out_intensity,
  input  wire logic              cfg_wr_en,
  input  wire logic [IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_W-1:0]  cfg_data
);

  // configuration registers
  logic [CFG_W-1:0] img_width_r, img_height_r;
  logic [1:0]       method_r;

  // sequencer state
  isi_state_t       state_r, state_nxt;
  logic [3:0]       idx_r, idx_nxt;
  logic             pend_r, pend_nxt;
  logic [3:0]       pend_idx_r, pend_idx_nxt;
  logic             out_valid_r, out_valid_nxt;
  logic [PIX_W-1:0] out_int_r, out_int_nxt;

  // per-sample datapath registers
  logic [POS_W-1:0]   pos_x_r, pos_y_r;
  logic [DIM_W-1:0]   w_r;
  logic [COORD_W-1:0] cols_r [4];
  logic [COORD_W-1:0] rows_r [4];
  logic [FRAC_BITS-1:0] fx_r, fy_r;
  logic signed [19:0] cdx_r, afx_r, cdy_r, afy_r;
  logic signed [WGT_W-1:0] wx_r [4];
  logic signed [WGT_W-1:0] wy_r [4];
  logic signed [ROW_W-1:0] row_sum_r;
  logic signed [ACC_W-1:0] acc_r;

  // frame store
  logic [PIX_W-1:0]  frame_mem [STORE_DEPTH];
  logic [PIX_W-1:0]  pixel_q_r;
  logic              mem_we;
  logic [ADDR_W-1:0] mem_addr, rd_addr;

  logic in_acc, is_cubic, is_lin, row_last;
  assign in_acc   = in_valid && !in_stall;
  assign is_cubic = (method_r == MTH_BICUBIC);
  assign is_lin   = (method_r == MTH_BILINEAR);
  assign mem_we   = in_acc && (in_cmd == CMD_WRITE);
  assign mem_addr = mem_we ? in_pixel_addr : rd_addr;
  assign in_stall = (state_r != ST_IDLE);
  assign out_valid     = out_valid_r;
  assign out_intensity = out_int_r;

  // last read of a row: nearest reads a single pixel
  assign row_last = (is_cubic || is_lin) ? (idx_r[1:0] == 2'd3) : (idx_r[1:0] == 2'd0);

  always_ff @(posedge clk) begin
    if (mem_we) begin
      frame_mem[mem_addr] <= in_pixel_value;
    end
    pixel_q_r <= frame_mem[mem_addr];
  end

  // config writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      img_width_r  <= CFG_W'(MAX_DIM);
      img_height_r <= CFG_W'(MAX_DIM);
      method_r     <= MTH_NEAREST;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        CFG_IMG_WIDTH:  img_width_r  <= cfg_data;
        CFG_IMG_HEIGHT: img_height_r <= cfg_data;
        CFG_METHOD:     method_r     <= cfg_data[1:0];
        default:        ;
      endcase
    end
  end

  // ---------------- setup 1: clamp position, neighbours, first products
  logic [DIM_W-1:0]   w_eff, h_eff;
  logic [COORD_W-1:0] ix_raw, iy_raw, ix_c, iy_c;
  logic [FRAC_BITS-1:0] fx_eff, fy_eff;
  logic signed [10:0] ax, cx, dx, ay, cy, dy, fxs1, fys1;
  logic signed [21:0] cdx_w, afx_w, cdy_w, afy_w;

  always_comb begin
    w_eff = (img_width_r == '0) ? DIM_W'(1) :
            (img_width_r > CFG_W'(MAX_DIM)) ? DIM_W'(MAX_DIM) : img_width_r;
    h_eff = (img_height_r == '0) ? DIM_W'(1) :
            (img_height_r > CFG_W'(MAX_DIM)) ? DIM_W'(MAX_DIM) : img_height_r;
    ix_raw = pos_x_r[POS_W-1:FRAC_BITS];
    iy_raw = pos_y_r[POS_W-1:FRAC_BITS];
    ix_c = ({1'b0, ix_raw} > (w_eff - DIM_W'(1))) ? COORD_W'(w_eff - DIM_W'(1)) : ix_raw;
    iy_c = ({1'b0, iy_raw} > (h_eff - DIM_W'(1))) ? COORD_W'(h_eff - DIM_W'(1)) : iy_raw;
    // nearest acts as bilinear at zero fraction
    fx_eff = (is_cubic || is_lin) ? pos_x_r[FRAC_BITS-1:0] : '0;
    fy_eff = (is_cubic || is_lin) ? pos_y_r[FRAC_BITS-1:0] : '0;
    fxs1 = $signed({3'b000, fx_eff});
    fys1 = $signed({3'b000, fy_eff});
    ax = fxs1 + 11'sd256;
    cx = fxs1 - 11'sd256;
    dx = fxs1 - 11'sd512;
    ay = fys1 + 11'sd256;
    cy = fys1 - 11'sd256;
    dy = fys1 - 11'sd512;
    cdx_w = 22'(cx) * 22'(dx);
    afx_w = 22'(ax) * 22'(fxs1);
    cdy_w = 22'(cy) * 22'(dy);
    afy_w = 22'(ay) * 22'(fys1);
  end

  // ---------------- setup 2: weights
  function automatic logic signed [WGT_W-1:0] cubic_wgt(
    input logic [FRAC_BITS-1:0] f,
    input logic signed [19:0]   cd,
    input logic signed [19:0]   af,
    input logic [1:0]           k
  );
    logic signed [WGT_W-1:0] fs, a, c, d, p;
    begin
      fs = $signed({{(WGT_W-FRAC_BITS){1'b0}}, f});
      a  = fs + WGT_W'(256);
      c  = fs - WGT_W'(256);
      d  = fs - WGT_W'(512);
      case (k)
        2'd0:    p = -(fs * WGT_W'(cd));
        2'd1:    p = WGT_W'(3) * (a * WGT_W'(cd));
        2'd2:    p = -(WGT_W'(3) * (WGT_W'(af) * d));
        default: p = WGT_W'(af) * c;
      endcase
      cubic_wgt = p;
    end
  endfunction

  logic [FRAC_BITS:0] bx [2];
  logic [FRAC_BITS:0] by [2];
  logic [2*FRAC_BITS+1:0] bw [4];

  always_comb begin
    bx[0] = (FRAC_BITS+1)'(1 << FRAC_BITS) - {1'b0, fx_r};
    bx[1] = {1'b0, fx_r};
    by[0] = (FRAC_BITS+1)'(1 << FRAC_BITS) - {1'b0, fy_r};
    by[1] = {1'b0, fy_r};
    for (int k = 0; k < 4; k++) begin
      bw[k] = (2*FRAC_BITS+2)'(bx[k%2]) * (2*FRAC_BITS+2)'(by[k/2]);
    end
  end

  // ---------------- read address
  logic [1:0]         rj, ri;
  logic [COORD_W-1:0] rd_col, rd_row;
  logic [16:0]        lin_addr;

  always_comb begin
    rj = idx_r[1:0];
    ri = idx_r[3:2];
    if (is_cubic) begin
      rd_col = cols_r[rj];
      rd_row = rows_r[ri];
    end else begin
      rd_col = rj[0] ? cols_r[2] : cols_r[1];
      rd_row = rj[1] ? rows_r[2] : rows_r[1];
    end
    lin_addr = 17'(rd_row) * 17'(w_r) + 17'(rd_col);
    rd_addr  = lin_addr[ADDR_W-1:0];
  end

  // ---------------- pixel times weight, row sum
  logic signed [PIX_W+WGT_W:0] pix_prod;
  assign pix_prod = $signed({1'b0, pixel_q_r}) * wx_r[pend_idx_r[1:0]];

  // ---------------- row sum times row weight, split in two halves
  logic signed [PART_W-1:0] part_a;
  logic signed [PART_W+WGT_W-1:0] part_prod;
  logic signed [ACC_W-1:0] acc_add;

  always_comb begin
    part_a = (state_r == ST_MUL_LO) ? $signed({1'b0, row_sum_r[SPLIT-1:0]})
                                    : row_sum_r[ROW_W-1:SPLIT];
    part_prod = (PART_W+WGT_W)'(part_a) * (PART_W+WGT_W)'(wy_r[idx_r[3:2]]);
    acc_add = (state_r == ST_MUL_LO) ? ACC_W'(part_prod) : (ACC_W'(part_prod) <<< SPLIT);
  end

  // ---------------- final scaling
  logic [V_W-1:0]   acc_v;
  logic [Q_W-1:0]   q_full;
  logic [PIX_W-1:0] cubic_res, lin_res, fin_res;

  always_comb begin
    acc_v  = acc_r[ACC_W-1:ACC_SH];
    q_full = Q_W'(acc_v[QV_W-1:0]) * Q_W'(RECIP_36);
    if (acc_r[ACC_W-1]) begin
      cubic_res = '0;
    end else if (acc_v >= V_W'(SAT_LIMIT)) begin
      cubic_res = '1;
    end else begin
      cubic_res = q_full[RECIP_SHIFT+PIX_W-1:RECIP_SHIFT];
    end
    lin_res = row_sum_r[2*FRAC_BITS+PIX_W-1:2*FRAC_BITS];
    fin_res = is_cubic ? cubic_res : lin_res;
  end

  // ---------------- sequencer
  always_comb begin
    state_nxt     = state_r;
    idx_nxt       = idx_r;
    pend_nxt      = 1'b0;
    pend_idx_nxt  = idx_r;
    out_valid_nxt = out_valid_r && out_stall;
    out_int_nxt   = out_int_r;
    case (state_r)
      ST_IDLE: begin
        if (in_acc && (in_cmd == CMD_SAMPLE)) begin
          state_nxt = ST_SETUP1;
        end
      end
      ST_SETUP1: state_nxt = ST_SETUP2;
      ST_SETUP2: begin
        state_nxt = ST_READ;
        idx_nxt   = '0;
      end
      ST_READ: begin
        pend_nxt = 1'b1;
        if (row_last) begin
          state_nxt = ST_LAST;
        end else begin
          idx_nxt = idx_r + 4'd1;
        end
      end
      ST_LAST:   state_nxt = is_cubic ? ST_MUL_LO : ST_FINISH;
      ST_MUL_LO: state_nxt = ST_MUL_HI;
      ST_MUL_HI: begin
        idx_nxt   = idx_r + 4'd1;
        state_nxt = (idx_r[3:2] == 2'd3) ? ST_FINISH : ST_READ;
      end
      ST_FINISH: begin
        if (!(out_valid_r && out_stall)) begin
          out_valid_nxt = 1'b1;
          out_int_nxt   = fin_res;
          state_nxt     = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      idx_r       <= '0;
      pend_r      <= 1'b0;
      pend_idx_r  <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      idx_r       <= idx_nxt;
      pend_r      <= pend_nxt;
      pend_idx_r  <= pend_idx_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    out_int_r <= out_int_nxt;
    if (in_acc && (in_cmd == CMD_SAMPLE)) begin
      pos_x_r <= in_pos_x;
      pos_y_r <= in_pos_y;
    end
    if (state_r == ST_SETUP1) begin
      w_r       <= w_eff;
      fx_r      <= fx_eff;
      fy_r      <= fy_eff;
      cdx_r     <= 20'(cdx_w);
      afx_r     <= 20'(afx_w);
      cdy_r     <= 20'(cdy_w);
      afy_r     <= 20'(afy_w);
      cols_r[0] <= (ix_c >= COORD_W'(1)) ? ix_c - COORD_W'(1) : ix_c;
      cols_r[1] <= ix_c;
      cols_r[2] <= ({1'b0, ix_c} + DIM_W'(1) < w_eff) ? ix_c + COORD_W'(1) : ix_c;
      cols_r[3] <= ({1'b0, ix_c} + DIM_W'(2) < w_eff) ? ix_c + COORD_W'(2) : ix_c;
      rows_r[0] <= (iy_c >= COORD_W'(1)) ? iy_c - COORD_W'(1) : iy_c;
      rows_r[1] <= iy_c;
      rows_r[2] <= ({1'b0, iy_c} + DIM_W'(1) < h_eff) ? iy_c + COORD_W'(1) : iy_c;
      rows_r[3] <= ({1'b0, iy_c} + DIM_W'(2) < h_eff) ? iy_c + COORD_W'(2) : iy_c;
      acc_r     <= '0;
    end else if (state_r == ST_MUL_LO || state_r == ST_MUL_HI) begin
      acc_r <= acc_r + acc_add;
    end
    if (state_r == ST_SETUP2) begin
      for (int k = 0; k < 4; k++) begin
        wx_r[k] <= is_cubic ? cubic_wgt(fx_r, cdx_r, afx_r, 2'(k))
                            : $signed(WGT_W'(bw[k]));
        wy_r[k] <= cubic_wgt(fy_r, cdy_r, afy_r, 2'(k));
      end
    end
    // row sum starts clean for each sample and each bicubic row
    if (state_r == ST_SETUP1 || state_r == ST_MUL_HI) begin
      row_sum_r <= '0;
    end else if (pend_r) begin
      row_sum_r <= row_sum_r + ROW_W'(pix_prod);
    end
  end

endmodule : image_sample_interpolator
`default_nettype wire

// ===== sv/isi_checker.sv =====
// port-level checks for the image sample interpolator, bound to the top level
`default_nettype none
module isi_checker
  import isi_pkg::*;
(
  input wire logic              clk,
  input wire logic              rst_n,
  input wire logic              in_valid,
  input wire logic              in_stall,
  input wire logic              in_cmd,
  input wire logic              out_valid,
  input wire logic              out_stall,
  input wire logic [PIX_W-1:0]  out_intensity
);

  // a stalled result transaction holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_intensity))
    else $error("result changed while stalled");

  // an accepted sample keeps the input side busy
  a_sample_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall && in_cmd == CMD_SAMPLE |=> in_stall)
    else $error("sample did not occupy the block");

  // a write never raises a result
  a_write_silent: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall && in_cmd == CMD_WRITE && !out_valid |=> !out_valid)
    else $error("write produced a result");

  // a new result only appears at the end of sample work
  a_result_from_work: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(in_stall))
    else $error("result without sample work");

endmodule : isi_checker

bind image_sample_interpolator isi_checker u_isi_checker (
  .clk           (clk),
  .rst_n         (rst_n),
  .in_valid      (in_valid),
  .in_stall      (in_stall),
  .in_cmd        (in_cmd),
  .out_valid     (out_valid),
  .out_stall     (out_stall),
  .out_intensity (out_intensity)
);
`default_nettype wire
